[hdl/channel_slot_window_finder_top_macros.svh]
// Assertion macros shared by the checker of the window finder.
// Include this header by its bare file name; it has no other dependencies.
`ifndef CHANNEL_SLOT_WINDOW_FINDER_TOP_MACROS_SVH
`define CHANNEL_SLOT_WINDOW_FINDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSWF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSWF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cswf_pkg.sv]
// Shared constants, field widths, status codes and control types for the
// channel slot window finder. No dependencies.
package cswf_pkg;

   // Field widths.
   localparam int TIME_W   = 64;
   localparam int GUARD_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int PERIOD_W = 16;
   localparam int PM_W     = 5;
   localparam int SEQB_W   = 16;
   localparam int STATUS_W = 2;

   // One time unit is 1024 us, a left shift by ten.
   localparam int TU_SHIFT = 10;
   // Extended window length: period times presence mode times one time unit.
   localparam int EAW_W    = PERIOD_W + PM_W + TU_SHIFT;

   // Channel sequence: the length is a power of two, so the slot wraps by mask.
   localparam int SEQ_BITS     = 4;
   localparam int SEQ_LEN      = 1 << SEQ_BITS;
   localparam int TABLE_SLOTS  = 16;
   localparam int MAX_PRESENCE = 16;

   // Counter widths.
   localparam int SCAN_W    = $clog2(SEQ_LEN + 1);
   localparam int DIV_CNT_W = $clog2(TIME_W);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_REF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SETUP_OK  = 3'd6;

   // Result status codes.
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_FOUND  = 2'd0;
   localparam status_type STATUS_REJECT = 2'd1;
   localparam status_type STATUS_NONE   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       div_init;
      logic       div_step;
      logic       small_step;
      logic       seed;
      logic       scan_step;
      logic       rsp_load;
      status_type rsp_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reject;
      logic hit;
      logic rsp_busy;
   } stat_type;

   // Channel held in a table slot; slots past the table read as channel zero.
   function automatic logic [CHAN_W-1:0] slot_channel(
      input logic [TIME_W-1:0]   seq_low,
      input logic [TIME_W-1:0]   seq_high,
      input logic [SEQ_BITS-1:0] slot
   );
      logic [2*TIME_W-1:0] tbl;
      int                  idx;
      tbl = {seq_high, seq_low};
      idx = int'(slot);
      if (idx >= TABLE_SLOTS) begin
         return '0;
      end
      return tbl[idx*CHAN_W +: CHAN_W];
   endfunction

endpackage

[hdl/cswf_if.sv]
// Channel interfaces of the window finder: request, response and register
// write. Depends on cswf_pkg for the field widths.
interface cswf_req_if;
   logic                            valid;
   logic                            ready;
   logic [cswf_pkg::CHAN_W-1:0]     wanted_channel;
   logic [cswf_pkg::TIME_W-1:0]     current_time_us;
   logic [cswf_pkg::GUARD_W-1:0]    guard_time_us;

   modport source (output valid, wanted_channel, current_time_us, guard_time_us,
                   input ready);
   modport sink   (input valid, wanted_channel, current_time_us, guard_time_us,
                   output ready);
endinterface

interface cswf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cswf_pkg::STATUS_W-1:0]   status;
   logic [cswf_pkg::TIME_W-1:0]     start_time_us;

   modport source (output valid, status, start_time_us, input ready);
   modport sink   (input valid, status, start_time_us, output ready);
endinterface

interface cswf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cswf_pkg::CSR_IDX_W-1:0]  index;
   logic [cswf_pkg::TIME_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/cswf_datapath.sv]
// Datapath of the window finder: register file, request capture, the two
// shift-subtract dividers, the slot scan and the response register. Uses cswf_pkg.
module cswf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   // Register writes.
   input  logic                            csr_write,
   input  logic [cswf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cswf_pkg::TIME_W-1:0]     csr_data,
   // Request word.
   input  logic [cswf_pkg::CHAN_W-1:0]     req_wanted_channel,
   input  logic [cswf_pkg::TIME_W-1:0]     req_current_time_us,
   input  logic [cswf_pkg::GUARD_W-1:0]    req_guard_time_us,
   // Response word.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cswf_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cswf_pkg::TIME_W-1:0]     rsp_start_time_us,
   // Controller link.
   input  cswf_pkg::cmd_type               cmd,
   output cswf_pkg::stat_type              stat
);

   // Configuration registers.
   logic [cswf_pkg::TIME_W-1:0]   sync_ff;
   logic [cswf_pkg::PERIOD_W-1:0] period_ff;
   logic [cswf_pkg::PM_W-1:0]     pm_ff;
   logic [cswf_pkg::SEQB_W-1:0]   seqb_ff;
   logic [cswf_pkg::TIME_W-1:0]   seq_low_ff;
   logic [cswf_pkg::TIME_W-1:0]   seq_high_ff;
   logic                          setup_ff;

   // Captured request and window length.
   logic [cswf_pkg::CHAN_W-1:0]   chan_ff;
   logic [cswf_pkg::TIME_W-1:0]   now_ff;
   logic [cswf_pkg::GUARD_W-1:0]  guard_ff;
   logic [cswf_pkg::EAW_W-1:0]    eaw_ff;
   logic [cswf_pkg::EAW_W-1:0]    eaw_in;

   // Divider state: elapsed windows and sequence base per presence mode.
   logic [cswf_pkg::TIME_W-1:0]   quot_ff;
   logic [cswf_pkg::TIME_W-1:0]   quot_in;
   logic [cswf_pkg::EAW_W-1:0]    rem_ff;
   logic [cswf_pkg::EAW_W-1:0]    rem_in;
   logic [cswf_pkg::EAW_W:0]      trial;
   logic [cswf_pkg::SEQB_W-1:0]   squot_ff;
   logic [cswf_pkg::SEQB_W-1:0]   squot_in;
   logic [cswf_pkg::PM_W-1:0]     srem_ff;
   logic [cswf_pkg::PM_W-1:0]     srem_in;
   logic [cswf_pkg::PM_W:0]       strial;

   // Scan state.
   logic [cswf_pkg::TIME_W-1:0]   cand_ff;
   logic [cswf_pkg::SEQ_BITS-1:0] slot_ff;

   // Response register.
   logic                          rsp_valid_ff;
   cswf_pkg::status_type          rsp_status_ff;
   logic [cswf_pkg::TIME_W-1:0]   rsp_start_ff;

   // Register file: the user must write it only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= '0;
         period_ff   <= '0;
         pm_ff       <= '0;
         seqb_ff     <= '0;
         seq_low_ff  <= '0;
         seq_high_ff <= '0;
         setup_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            cswf_pkg::REG_SYNC_REF: sync_ff     <= csr_data;
            cswf_pkg::REG_PERIOD:   period_ff   <= csr_data[cswf_pkg::PERIOD_W-1:0];
            cswf_pkg::REG_PRESENCE: pm_ff       <= csr_data[cswf_pkg::PM_W-1:0];
            cswf_pkg::REG_SEQ_BASE: seqb_ff     <= csr_data[cswf_pkg::SEQB_W-1:0];
            cswf_pkg::REG_SEQ_LOW:  seq_low_ff  <= csr_data;
            cswf_pkg::REG_SEQ_HIGH: seq_high_ff <= csr_data;
            cswf_pkg::REG_SETUP_OK: setup_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Window length in microseconds from period and presence mode; the product
   // is formed at the full window width so that no bits are lost.
   assign eaw_in = (cswf_pkg::EAW_W'(period_ff) * cswf_pkg::EAW_W'(pm_ff)) <<
                   cswf_pkg::TU_SHIFT;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_ff  <= req_wanted_channel;
         now_ff   <= req_current_time_us;
         guard_ff <= req_guard_time_us;
         eaw_ff   <= eaw_in;
      end
   end

   // Rejection of an invalid setup or request.
   assign stat.reject = !setup_ff || (period_ff == '0) || (pm_ff == '0) ||
                        (pm_ff > cswf_pkg::PM_W'(cswf_pkg::MAX_PRESENCE)) ||
                        (chan_ff == '0) || (now_ff < sync_ff) ||
                        (guard_ff >= cswf_pkg::GUARD_W'(eaw_ff));

   // One restoring step of each divider.
   always_comb begin
      trial  = {rem_ff, quot_ff[cswf_pkg::TIME_W-1]};
      strial = {srem_ff, squot_ff[cswf_pkg::SEQB_W-1]};
      if (trial >= {1'b0, eaw_ff}) begin
         rem_in  = cswf_pkg::EAW_W'(trial - {1'b0, eaw_ff});
         quot_in = {quot_ff[cswf_pkg::TIME_W-2:0], 1'b1};
      end else begin
         rem_in  = trial[cswf_pkg::EAW_W-1:0];
         quot_in = {quot_ff[cswf_pkg::TIME_W-2:0], 1'b0};
      end
      if (strial >= {1'b0, pm_ff}) begin
         srem_in  = cswf_pkg::PM_W'(strial - {1'b0, pm_ff});
         squot_in = {squot_ff[cswf_pkg::SEQB_W-2:0], 1'b1};
      end else begin
         srem_in  = strial[cswf_pkg::PM_W-1:0];
         squot_in = {squot_ff[cswf_pkg::SEQB_W-2:0], 1'b0};
      end
   end

   // Divider registers.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quot_ff  <= now_ff - sync_ff;
         rem_ff   <= '0;
         squot_ff <= seqb_ff;
         srem_ff  <= '0;
      end else begin
         if (cmd.div_step) begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
         end
         if (cmd.small_step) begin
            squot_ff <= squot_in;
            srem_ff  <= srem_in;
         end
      end
   end

   // Scan: the current window starts at now minus the remainder; each step
   // moves one extended window ahead and one slot along the sequence.
   always_ff @(posedge clock) begin
      if (cmd.seed) begin
         cand_ff <= now_ff - cswf_pkg::TIME_W'(rem_ff) + cswf_pkg::TIME_W'(guard_ff);
         slot_ff <= squot_ff[cswf_pkg::SEQ_BITS-1:0] + quot_ff[cswf_pkg::SEQ_BITS-1:0];
      end else if (cmd.scan_step) begin
         cand_ff <= cand_ff + cswf_pkg::TIME_W'(eaw_ff);
         slot_ff <= slot_ff + 1'b1;
      end
   end

   assign stat.hit = (cswf_pkg::slot_channel(seq_low_ff, seq_high_ff, slot_ff) == chan_ff) &&
                     (cand_ff >= now_ff);

   // Response register: holds its word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_start_ff  <= (cmd.rsp_code == cswf_pkg::STATUS_FOUND) ? cand_ff : '0;
      end
   end

   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_start_time_us = rsp_start_ff;

endmodule

[hdl/cswf_ctrl.sv]
// Controller of the window finder: sequences capture, check, division,
// slot scan and response load. Uses cswf_pkg for the command and status types.
module cswf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cswf_pkg::stat_type stat,
   output cswf_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_SEED   = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [cswf_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [cswf_pkg::DIV_CNT_W-1:0] cnt_in;
   logic [cswf_pkg::SCAN_W-1:0]    scan_ff;
   logic [cswf_pkg::SCAN_W-1:0]    scan_in;
   cswf_pkg::status_type           code_ff;
   cswf_pkg::status_type           code_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      scan_in   = scan_ff;
      code_in   = code_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.reject) begin
               code_in  = cswf_pkg::STATUS_REJECT;
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // One quotient bit per cycle; the short division ends early.
            cmd.div_step   = 1'b1;
            cmd.small_step = (cnt_ff < cswf_pkg::DIV_CNT_W'(cswf_pkg::SEQB_W));
            if (cnt_ff == cswf_pkg::DIV_CNT_W'(cswf_pkg::TIME_W - 1)) begin
               state_in = ST_SEED;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               code_in  = cswf_pkg::STATUS_FOUND;
               state_in = ST_FINISH;
            end else if (scan_ff == cswf_pkg::SCAN_W'(cswf_pkg::SEQ_LEN)) begin
               code_in  = cswf_pkg::STATUS_NONE;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
               scan_in       = scan_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.rsp_code = code_ff;
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         scan_ff  <= '0;
         code_ff  <= cswf_pkg::STATUS_REJECT;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         scan_ff  <= scan_in;
         code_ff  <= code_in;
      end
   end

endmodule

[hdl/channel_slot_window_finder_top.sv]
// Top level of the channel slot window finder: joins controller and datapath
// to the request, response and register-write channels. Uses cswf_pkg, cswf_if.
//
// Usage:
//  - csr_ch writes one configuration register per word; it is always ready.
//    Write registers only while no request is in flight.
//  - req_ch carries one request word (wanted channel, current time, guard).
//    A word is taken when valid and ready are both high; ready is high only
//    while no request is being worked on.
//  - rsp_ch returns one word per request: status and start time.
//  - A rejected request goes from the check straight to the response load;
//    otherwise the bit-serial division of the elapsed time by the window
//    length and the scan of up to 17 slots, one per cycle, come in between.
//    The next request is taken in the cycle after the response is loaded.
//  - The response sits in an output register: a stalled receiver does not
//    block the next request, but that request's response waits until the
//    previous word is taken.
//  - Synchronous reset clears the configuration registers, returns the controller to idle and empties the response.
module channel_slot_window_finder_top (
   input  logic        clock,
   input  logic        reset,
   cswf_req_if.sink    req_ch,
   cswf_rsp_if.source  rsp_ch,
   cswf_csr_if.sink    csr_ch
);

   cswf_pkg::cmd_type  cmd;
   cswf_pkg::stat_type stat;
   logic               req_ready;

   // Register writes are taken at once.
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   // Sequencer.
   cswf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic, registers and response.
   cswf_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .req_wanted_channel  (req_ch.wanted_channel),
      .req_current_time_us (req_ch.current_time_us),
      .req_guard_time_us   (req_ch.guard_time_us),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_status          (rsp_ch.status),
      .rsp_start_time_us   (rsp_ch.start_time_us),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

[hdl/cswf_checker.sv]
// Port-level checker of the window finder, bound to the top level.
// Uses cswf_pkg and the macros in channel_slot_window_finder_top_macros.svh.
`include "channel_slot_window_finder_top_macros.svh"

module cswf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cswf_pkg::STATUS_W-1:0] rsp_status,
   input logic [cswf_pkg::TIME_W-1:0]   rsp_start_time_us
);

   // A taken request keeps the block busy in the following cycle.
   `CSWF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // A response only carries a defined status code.
   `CSWF_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, (rsp_status == cswf_pkg::STATUS_FOUND) || (rsp_status == cswf_pkg::STATUS_REJECT) || (rsp_status == cswf_pkg::STATUS_NONE), "undefined status code")

   // Start time is zero unless a window was found.
   `CSWF_ASSERT_SAME(a_start_zero, clock, reset, rsp_valid && (rsp_status != cswf_pkg::STATUS_FOUND), rsp_start_time_us == '0, "start time set without a found window")

   // A stalled response word holds.
   `CSWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_start_time_us), "stalled response changed")

endmodule

bind channel_slot_window_finder_top cswf_checker u_cswf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_start_time_us (rsp_ch.start_time_us)
);

[test/tb_channel_slot_window_finder_top.sv]
`timescale 1ns / 1ps
// Testbench of the channel slot window finder: a directed table of register writes and
// requests, then random register settings with random request words, all checked.
// Depends on cswf_pkg, the cswf interfaces and channel_slot_window_finder_top.
module tb_channel_slot_window_finder_top;

   localparam int CYCLE_LIMIT    = 1_500_000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_QUERIES = 1530;
   localparam logic [cswf_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam logic [cswf_pkg::TIME_W-1:0]    TIME_MAX  = '1;
   localparam logic [cswf_pkg::TIME_W-1:0]    TU_US     = 64'd1024;

   typedef struct packed {
      cswf_pkg::status_type        status;
      logic [cswf_pkg::TIME_W-1:0] found_us;
   } window_type;

   typedef enum logic [1:0] { ROW_WRITE, ROW_QUERY, ROW_KNOWN } row_kind_type;

   // One line of the directed table: a register write, or a request whose
   // answer comes from the predictor or is typed in.
   typedef struct packed {
      row_kind_type                   kind;
      logic [cswf_pkg::CSR_IDX_W-1:0] index;
      logic [cswf_pkg::TIME_W-1:0]    data;
      logic [cswf_pkg::CHAN_W-1:0]    chan;
      logic [cswf_pkg::GUARD_W-1:0]   guard;
      window_type                     known;
   } plan_row_type;

   typedef enum int { SINK_OPEN, SINK_CADENCE, SINK_COIN, SINK_SPARSE } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cswf_req_if req_if ();
   cswf_rsp_if rsp_if ();
   cswf_csr_if csr_if ();

   channel_slot_window_finder_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Bench copy of the schedule registers.
   logic [cswf_pkg::TIME_W-1:0]   sched_sync_ref = '0;
   logic [cswf_pkg::PERIOD_W-1:0] sched_period   = '0;
   logic [cswf_pkg::PM_W-1:0]     sched_presence = '0;
   logic [cswf_pkg::SEQB_W-1:0]   sched_seq_base = '0;
   logic [cswf_pkg::TIME_W-1:0]   sched_seq_low  = '0;
   logic [cswf_pkg::TIME_W-1:0]   sched_seq_high = '0;
   logic                          sched_setup_ok = 1'b0;

   window_type   expected_windows [$];
   plan_row_type directed_plan [$];

   int  cycle_count     = 0;
   int  mismatch_count  = 0;
   int  queries_sent    = 0;
   int  results_seen    = 0;
   int  found_count     = 0;
   int  rejected_count  = 0;
   int  none_count      = 0;
   int  register_writes = 0;
   int  settings_loaded = 0;
   logic csr_open       = 1'b0;

   always #1 clock = ~clock;

   // Mirror a register write into the bench copy, with the same width masks.
   function automatic void apply_register(input logic [cswf_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [cswf_pkg::TIME_W-1:0] data);
      case (idx)
         cswf_pkg::REG_SYNC_REF: sched_sync_ref = data;
         cswf_pkg::REG_PERIOD:   sched_period   = data[cswf_pkg::PERIOD_W-1:0];
         cswf_pkg::REG_PRESENCE: sched_presence = data[cswf_pkg::PM_W-1:0];
         cswf_pkg::REG_SEQ_BASE: sched_seq_base = data[cswf_pkg::SEQB_W-1:0];
         cswf_pkg::REG_SEQ_LOW:  sched_seq_low  = data;
         cswf_pkg::REG_SEQ_HIGH: sched_seq_high = data;
         cswf_pkg::REG_SETUP_OK: sched_setup_ok = data[0];
         default: ;
      endcase
   endfunction

   // Earliest extended window on the wanted channel whose start plus guard
   // is not before now, scanning the window in progress and 16 more.
   function automatic window_type find_window(input logic [cswf_pkg::CHAN_W-1:0] chan,
                                              input logic [cswf_pkg::TIME_W-1:0] now,
                                              input logic [cswf_pkg::GUARD_W-1:0] guard);
      window_type                    w;
      logic [cswf_pkg::TIME_W-1:0]   span, elapsed, origin, first_slot, slot, cand;
      logic [2*cswf_pkg::TIME_W-1:0] chan_table;
      logic [cswf_pkg::CHAN_W-1:0]   held;
      w.status   = cswf_pkg::STATUS_REJECT;
      w.found_us = '0;
      if (!sched_setup_ok || sched_period == 0 || sched_presence == 0 ||
          sched_presence > cswf_pkg::MAX_PRESENCE || chan == 0 ||
          now < sched_sync_ref) begin
         return w;
      end
      span = cswf_pkg::TIME_W'(sched_period) * cswf_pkg::TIME_W'(sched_presence) * TU_US;
      if (cswf_pkg::TIME_W'(guard) >= span) begin
         return w;
      end
      elapsed    = (now - sched_sync_ref) / span;
      origin     = sched_sync_ref + elapsed * span;
      first_slot = cswf_pkg::TIME_W'(sched_seq_base) / cswf_pkg::TIME_W'(sched_presence);
      chan_table = {sched_seq_high, sched_seq_low};
      w.status   = cswf_pkg::STATUS_NONE;
      for (int k = 0; k <= cswf_pkg::SEQ_LEN; k++) begin
         slot = (first_slot + elapsed + cswf_pkg::TIME_W'(k)) %
                cswf_pkg::TIME_W'(cswf_pkg::SEQ_LEN);
         held = (slot < cswf_pkg::TABLE_SLOTS) ?
                chan_table[int'(slot)*cswf_pkg::CHAN_W +: cswf_pkg::CHAN_W] : '0;
         // The sum wraps at 64 bits; a wrapped candidate lands before now.
         cand = origin + cswf_pkg::TIME_W'(k) * span + cswf_pkg::TIME_W'(guard);
         if (held == chan && cand >= now) begin
            w.status   = cswf_pkg::STATUS_FOUND;
            w.found_us = cand;
            return w;
         end
      end
      return w;
   endfunction

   function automatic plan_row_type reg_row(input logic [cswf_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [cswf_pkg::TIME_W-1:0] data);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   function automatic plan_row_type query_row(input logic [cswf_pkg::CHAN_W-1:0] chan,
                                              input logic [cswf_pkg::TIME_W-1:0] now,
                                              input logic [cswf_pkg::GUARD_W-1:0] guard);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_QUERY;
      r.chan  = chan;
      r.data  = now;
      r.guard = guard;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [cswf_pkg::CHAN_W-1:0] chan,
                                              input logic [cswf_pkg::TIME_W-1:0] now,
                                              input logic [cswf_pkg::GUARD_W-1:0] guard,
                                              input cswf_pkg::status_type st,
                                              input logic [cswf_pkg::TIME_W-1:0] found_us);
      plan_row_type r;
      r                = query_row(chan, now, guard);
      r.kind           = ROW_KNOWN;
      r.known.status   = st;
      r.known.found_us = found_us;
      return r;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [cswf_pkg::TIME_W-1:0] got,
                                  input logic [cswf_pkg::TIME_W-1:0] want);
      $display("[%0t] mismatch: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Write one register word; valid stays high for a following write.
   task automatic write_register(input logic [cswf_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [cswf_pkg::TIME_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      csr_open = 1'b1;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      apply_register(idx, data);
      register_writes++;
      @(negedge clock);
   endtask

   // Offer one request word and record its expected answer once it is taken.
   task automatic send_query(input logic [cswf_pkg::CHAN_W-1:0] chan,
                             input logic [cswf_pkg::TIME_W-1:0] now,
                             input logic [cswf_pkg::GUARD_W-1:0] guard,
                             input logic typed, input window_type known);
      req_if.valid           <= 1'b1;
      req_if.wanted_channel  <= chan;
      req_if.current_time_us <= now;
      req_if.guard_time_us   <= guard;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      expected_windows.push_back(typed ? known : find_window(chan, now, guard));
      queries_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Let every answer come back and the block fall idle.
   task automatic drain_queries();
      req_if.valid <= 1'b0;
      while (expected_windows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Pick and write a new schedule; now and then one flaw makes it unusable.
   task automatic load_schedule(input int phase, output logic flawed);
      logic [cswf_pkg::TIME_W-1:0]   sync_ref, seq_low, seq_high, spare;
      logic [cswf_pkg::PERIOD_W-1:0] period;
      logic [cswf_pkg::PM_W-1:0]     presence;
      logic                          setup_ok;
      int                            pool;
      spare = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: sync_ref = '0;
         1: sync_ref = {$urandom, $urandom};
         2: sync_ref = TIME_MAX - cswf_pkg::TIME_W'($urandom_range(0, 1 << 24));
         default: sync_ref = cswf_pkg::TIME_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
         0: period = cswf_pkg::PERIOD_W'($urandom_range(1, 8));
         1: period = cswf_pkg::PERIOD_W'($urandom_range(1, 65535));
         default: period = '1;
      endcase
      presence = cswf_pkg::PM_W'($urandom_range(1, cswf_pkg::MAX_PRESENCE));
      // Extremes first: shortest window, longest window, reference near the top.
      if (phase == 0) begin
         sync_ref = '0;
         period   = cswf_pkg::PERIOD_W'(1);
         presence = cswf_pkg::PM_W'(1);
      end else if (phase == 1) begin
         period   = '1;
         presence = cswf_pkg::PM_W'(cswf_pkg::MAX_PRESENCE);
      end else if (phase == 2) begin
         sync_ref = TIME_MAX - cswf_pkg::TIME_W'($urandom_range(0, 4096));
      end
      // A small channel pool repeats channels across slots; a fully random
      // table now and then reaches every channel number.
      pool = $urandom_range(2, 20);
      for (int b = 0; b < 8; b++) begin
         seq_low[b*cswf_pkg::CHAN_W +: cswf_pkg::CHAN_W] =
            cswf_pkg::CHAN_W'($urandom_range(0, pool));
         seq_high[b*cswf_pkg::CHAN_W +: cswf_pkg::CHAN_W] =
            cswf_pkg::CHAN_W'($urandom_range(0, pool));
      end
      if ($urandom_range(0, 3) == 0) begin
         seq_low  = {$urandom, $urandom};
         seq_high = {$urandom, $urandom};
      end
      setup_ok = 1'b1;
      flawed   = phase > 2 && $urandom_range(0, 5) == 0;
      if (flawed) begin
         case ($urandom_range(0, 3))
            0: setup_ok = 1'b0;
            1: period = '0;
            2: presence = '0;
            default: presence =
               cswf_pkg::PM_W'($urandom_range(cswf_pkg::MAX_PRESENCE + 1, 31));
         endcase
      end
      // Unused upper bits of the narrow registers carry random noise.
      write_register(cswf_pkg::REG_SYNC_REF, sync_ref);
      write_register(cswf_pkg::REG_PERIOD,
                     {spare[cswf_pkg::TIME_W-1:cswf_pkg::PERIOD_W], period});
      write_register(cswf_pkg::REG_PRESENCE,
                     {spare[cswf_pkg::TIME_W-1:cswf_pkg::PM_W], presence});
      write_register(cswf_pkg::REG_SEQ_BASE,
                     {spare[cswf_pkg::TIME_W-1:cswf_pkg::SEQB_W],
                      cswf_pkg::SEQB_W'($urandom)});
      write_register(cswf_pkg::REG_SEQ_LOW, seq_low);
      write_register(cswf_pkg::REG_SEQ_HIGH, seq_high);
      if ($urandom_range(0, 3) == 0) begin
         write_register(REG_SPARE, spare);
      end
      write_register(cswf_pkg::REG_SETUP_OK, {spare[cswf_pkg::TIME_W-1:1], setup_ok});
      settings_loaded++;
   endtask

   // Mostly well-formed requests: a channel from the table, a time after the
   // reference near window edges, a guard below the window length.
   task automatic random_query();
      logic [cswf_pkg::CHAN_W-1:0]  chan;
      logic [cswf_pkg::TIME_W-1:0]  now, span, offset, r64;
      logic [cswf_pkg::GUARD_W-1:0] guard;
      int                           slot;
      span = (sched_period == 0 || sched_presence == 0) ? TU_US :
             cswf_pkg::TIME_W'(sched_period) * cswf_pkg::TIME_W'(sched_presence) * TU_US;
      r64  = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 85) begin
         slot = $urandom_range(0, 15);
         chan = (slot < 8) ? sched_seq_low[slot*cswf_pkg::CHAN_W +: cswf_pkg::CHAN_W] :
                sched_seq_high[(slot-8)*cswf_pkg::CHAN_W +: cswf_pkg::CHAN_W];
         if ($urandom_range(0, 9) == 0) begin
            chan = cswf_pkg::CHAN_W'($urandom_range(1, 255));
         end
         case ($urandom_range(0, 3))
            0: offset = cswf_pkg::TIME_W'($urandom_range(0, 40)) * span + (r64 % span);
            1: offset = cswf_pkg::TIME_W'($urandom_range(0, 1 << 20)) * span;
            2: offset = cswf_pkg::TIME_W'($urandom_range(1, 40)) * span - 1;
            default: offset = r64 % (span * 64'd20);
         endcase
         now = sched_sync_ref + offset;
         case ($urandom_range(0, 3))
            0: guard = '0;
            1: guard = cswf_pkg::GUARD_W'(span - 1);
            default: guard = cswf_pkg::GUARD_W'(cswf_pkg::TIME_W'($urandom) % span);
         endcase
      end else begin
         // Noise: any channel, times before the reference, oversized guards.
         chan  = cswf_pkg::CHAN_W'($urandom_range(0, 255));
         now   = ($urandom_range(0, 1) == 1) ? r64 :
                 sched_sync_ref - cswf_pkg::TIME_W'($urandom_range(1, 5000));
         guard = ($urandom_range(0, 1) == 1) ? cswf_pkg::GUARD_W'($urandom) :
                 cswf_pkg::GUARD_W'(span) + cswf_pkg::GUARD_W'($urandom_range(0, 10));
      end
      send_query(chan, now, guard, 1'b0, '0);
   endtask

   // Compare each response word with the oldest expectation.
   always @(posedge clock) begin : response_check
      window_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         case (rsp_if.status)
            cswf_pkg::STATUS_FOUND:  found_count++;
            cswf_pkg::STATUS_REJECT: rejected_count++;
            default:                 none_count++;
         endcase
         if (expected_windows.size() == 0) begin
            report_mismatch("response word with no request waiting",
                            cswf_pkg::TIME_W'(rsp_if.status), '0);
         end else begin
            want = expected_windows.pop_front();
            if (rsp_if.status !== want.status) begin
               report_mismatch("status", cswf_pkg::TIME_W'(rsp_if.status),
                               cswf_pkg::TIME_W'(want.status));
            end
            if (rsp_if.start_time_us !== want.found_us) begin
               report_mismatch("start time", rsp_if.start_time_us, want.found_us);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
                  expected_windows.size());
         $display("** channel_slot_window_finder_top: FAILED **");
         $finish;
      end
   end

   // Receiver: picks a new stall pattern at random whenever the current one runs out.
   initial begin : receiver
      sink_mode_type mode;
      int            hold;
      int            tick;
      rsp_if.ready = 1'b0;
      mode = SINK_OPEN;
      hold = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            hold = $urandom_range(20, 300);
         end else begin
            hold--;
         end
         tick++;
         case (mode)
            SINK_OPEN:    rsp_if.ready <= 1'b1;
            SINK_CADENCE: rsp_if.ready <= (tick % 5) >= 2;
            SINK_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
            default:      rsp_if.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   initial begin : stimulus
      plan_row_type row;
      logic         flawed;
      logic         query_pending;
      int           phase;
      int           phase_size;
      int           burst;
      int           gap;
      int           random_queries;

      req_if.valid           = 1'b0;
      req_if.wanted_channel  = '0;
      req_if.current_time_us = '0;
      req_if.guard_time_us   = '0;
      csr_if.valid           = 1'b0;
      csr_if.index           = '0;
      csr_if.data            = '0;
      query_pending          = 1'b0;

      // Slots 0..15 hold channels 1..16 in the directed schedule.
      directed_plan = '{
         known_row(8'd1, 64'd0, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_SYNC_REF, 64'd1000),
         reg_row(cswf_pkg::REG_PERIOD, 64'd1),
         reg_row(cswf_pkg::REG_PRESENCE, 64'd1),
         reg_row(cswf_pkg::REG_SEQ_BASE, 64'd0),
         reg_row(cswf_pkg::REG_SEQ_LOW, 64'h0807_0605_0403_0201),
         reg_row(cswf_pkg::REG_SEQ_HIGH, 64'h100F_0E0D_0C0B_0A09),
         reg_row(cswf_pkg::REG_SETUP_OK, 64'd1),
         reg_row(REG_SPARE, TIME_MAX),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_FOUND, 64'd1000),
         known_row(8'd1, 64'd1000, 32'd1023, cswf_pkg::STATUS_FOUND, 64'd2023),
         known_row(8'd0, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         known_row(8'd1, 64'd999, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         known_row(8'd1, 64'd1000, 32'd1024, cswf_pkg::STATUS_REJECT, '0),
         known_row(8'hFF, 64'd1000, 32'd0, cswf_pkg::STATUS_NONE, '0),
         query_row(8'd2, 64'd1500, 32'd5),
         query_row(8'd1, 64'd1500, 32'd0),
         known_row(8'd16, TIME_MAX, 32'hFFFF_FFFF, cswf_pkg::STATUS_REJECT, '0),
         query_row(8'd9, TIME_MAX, 32'd0),
         reg_row(cswf_pkg::REG_SETUP_OK, 64'hFFFF_FFFF_FFFF_FFFE),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_SETUP_OK, 64'd1),
         reg_row(cswf_pkg::REG_PERIOD, 64'hFFFF_FFFF_FFFF_0000),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_PERIOD, 64'hFFFF),
         reg_row(cswf_pkg::REG_PRESENCE, 64'd0),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_PRESENCE, 64'd17),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_PRESENCE, TIME_MAX),
         known_row(8'd1, 64'd1000, 32'd0, cswf_pkg::STATUS_REJECT, '0),
         reg_row(cswf_pkg::REG_PRESENCE, 64'd16),
         reg_row(cswf_pkg::REG_SEQ_BASE, TIME_MAX),
         query_row(8'd4, 64'd5_000_001_000, 32'h3FFF_BFFF),
         query_row(8'd16, TIME_MAX, 32'd0),
         // Reference just below the top of time: later windows wrap to small values.
         reg_row(cswf_pkg::REG_SYNC_REF, 64'hFFFF_FFFF_FFFF_EC78),
         reg_row(cswf_pkg::REG_PERIOD, 64'd1),
         reg_row(cswf_pkg::REG_PRESENCE, 64'd1),
         reg_row(cswf_pkg::REG_SEQ_BASE, 64'd0),
         query_row(8'd1, TIME_MAX, 32'd0),
         query_row(8'd5, TIME_MAX, 32'd100),
         query_row(8'd6, 64'hFFFF_FFFF_FFFF_EC78, 32'd0),
         reg_row(cswf_pkg::REG_SYNC_REF, 64'd0),
         known_row(8'd1, 64'd0, 32'd0, cswf_pkg::STATUS_FOUND, 64'd0)
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed table; registers change only once all answers are back.
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_WRITE) begin
            if (query_pending) begin
               drain_queries();
               query_pending = 1'b0;
            end
            write_register(row.index, row.data);
         end else begin
            if (csr_open) begin
               csr_if.valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_query(row.chan, row.data, row.guard, row.kind == ROW_KNOWN, row.known);
            query_pending = 1'b1;
         end
      end

      // Random schedules, each followed by bursts of request words with gaps.
      random_queries = 0;
      phase          = 0;
      while (random_queries < RANDOM_QUERIES) begin
         drain_queries();
         load_schedule(phase, flawed);
         csr_if.valid <= 1'b0;
         csr_open = 1'b0;
         phase_size = flawed ? 24 : 128;
         burst      = 0;
         for (int i = 0; i < phase_size && random_queries < RANDOM_QUERIES; i++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 12);
               case ($urandom_range(0, 3))
                  0: gap = 0;
                  1: gap = $urandom_range(1, 4);
                  2: gap = $urandom_range(5, 40);
                  default: gap = $urandom_range(41, 120);
               endcase
               if (gap > 0) begin
                  pause_sender(gap);
               end
            end
            burst--;
            random_query();
            random_queries++;
         end
         phase++;
      end

      drain_queries();
      $display("Sent %0d request words over %0d schedules with %0d register writes.",
               queries_sent, settings_loaded, register_writes);
      $display("Answers: %0d found, %0d rejected, %0d with no window, %0d in all.",
               found_count, rejected_count, none_count, results_seen);
      if (mismatch_count == 0) begin
         $display("** channel_slot_window_finder_top: PASSED **");
      end else begin
         $display("** channel_slot_window_finder_top: FAILED **");
      end
      $finish;
   end

endmodule
